// ===== hdl/first_fit_heap_allocator_defines.svh =====
// Assertion macros for the first-fit heap allocator.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// check on every clock edge outside reset
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs while reset is applied
`define FFHA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hdl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// No dependencies; used by ffha_store and first_fit_heap_allocator.
package ffha_pkg;

  localparam int CNT_W     = 13;
  localparam int LINK_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [LINK_W-1:0] LINK_NONE = 16'hFFFF;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REALLOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

  // one 16-bit little-endian access to the byte store
  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } store_req_t;

endpackage

// ===== hdl/ffha_store.sv =====
// Byte store of the heap, split into even and odd byte banks so that a
// 16-bit word at any byte offset is one access. Depends on ffha_pkg.
module ffha_store import ffha_pkg::*; #(
  parameter int AW = 12
) (
  input  logic              clk,
  input  store_req_t        req,
  output logic [LINK_W-1:0] rdata
);

  localparam int HALF = 1 << (AW - 1);

  logic [7:0] bank_even [HALF];
  logic [7:0] bank_odd  [HALF];

  logic [AW-1:0] idx0;
  logic [AW-1:0] idx1;
  logic [AW-1:0] idx_even;
  logic [AW-2:0] even_addr;
  logic [AW-2:0] odd_addr;
  logic [7:0]    even_wdata;
  logic [7:0]    odd_wdata;
  logic [7:0]    even_q;
  logic [7:0]    odd_q;
  logic          odd_sel;

  assign idx0       = req.addr[AW-1:0];
  assign idx1       = idx0 + AW'(1);
  assign idx_even   = req.addr[0] ? idx1 : idx0;
  assign even_addr  = idx_even[AW-1:1];
  assign odd_addr   = idx0[AW-1:1];
  assign even_wdata = req.addr[0] ? req.wdata[15:8] : req.wdata[7:0];
  assign odd_wdata  = req.addr[0] ? req.wdata[7:0] : req.wdata[15:8];

  always_ff @(posedge clk) begin
    if (req.we) begin
      bank_even[even_addr] <= even_wdata;
      bank_odd[odd_addr]   <= odd_wdata;
    end
    even_q  <= bank_even[even_addr];
    odd_q   <= bank_odd[odd_addr];
    odd_sel <= req.addr[0];
  end

  assign rdata = odd_sel ? {even_q, odd_q} : {odd_q, even_q};

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: request stream in, one result word out per request.
// Slave side takes a request word (s_tuser = func; s_tdata = size, address).
// Master side returns result address, ok, moved, copy length and byte counts.
// Configuration: cfg_we/cfg_index/cfg_data write heap_base (0) or heap_limit (1)
// while no request is in flight; the user must keep to this, the block does not enforce it.
// The free list lives in a byte store (two 8-bit banks, registered read) that a
// sequencer walks; every link or size read sets the address in one state and uses the data in the next.
// Steps from the accepting edge until m_tvalid rises:
//   first request after reset: the single free block is laid out first
//   allocate: first-fit walk over the free nodes, then unlink or split the block
//   free: walk the nodes ahead of the block, link it in (or append it at the end),
//         then a merge pass over the list that joins adjacent blocks
//   reallocate: in place, grown into the adjacent free block, or allocate then free
// One request is handled at a time; s_tready is high only when the sequencer
// is idle. A finished result sits in the output register, so a new request is
// taken while the receiver stalls; the next result waits until m_tready.
// Reset (rst, synchronous) empties the list and clears the counters; the store
// needs no clearing since it is laid out by the first request.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_MAX   = 4096,
  parameter int NODE_BYTES = 6,
  parameter int MIN_SPLIT  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,  // size[12:0], address[28:13], zero fill
  input  logic [1:0]           s_tuser,  // func[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,  // result_address[15:0], ok[16], moved[17],
                                         // copy_length[30:18], used_bytes[43:31],
                                         // free_bytes[56:44], zero fill
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

`include "first_fit_heap_allocator_defines.svh"

  localparam int AW = $clog2(HEAP_MAX);
  localparam int SW = AW + 1;

  typedef enum logic [5:0] {
    ST_IDLE, ST_INIT_NX, ST_INIT_PV, ST_INIT_SZ, ST_DISPATCH,
    ST_A_LOOP, ST_A_SZ, ST_A_NX,
    ST_T_SZ, ST_T_PV, ST_T_NX, ST_T_DEC,
    ST_T_S1, ST_T_S2, ST_T_S3, ST_T_S4, ST_T_S5, ST_T_S6,
    ST_T_U1, ST_T_U2, ST_T_TK, ST_T_TK2,
    ST_I_SZ, ST_I_BS, ST_I_LOOP, ST_I_NX,
    ST_I_F1, ST_I_F2, ST_I_F3, ST_I_F4, ST_I_E1, ST_I_E2, ST_I_E3,
    ST_M_INIT, ST_M_LOOP, ST_M_N, ST_M_CHK, ST_M_SUM, ST_M_NX, ST_M_PV,
    ST_R_SZ, ST_R_OS, ST_F_LOOP, ST_F_SZ, ST_F_NX,
    ST_G_SZ, ST_G_WR, ST_V_SZ, ST_V_CP, ST_DONE
  } state_t;

  typedef enum logic [1:0] {RET_ALLOC, RET_MOVE, RET_GROW} ret_t;

  state_t state;
  ret_t   ret;

  logic [1:0]        func;
  logic [CNT_W-1:0]  size;
  logic [LINK_W-1:0] address;
  logic [LINK_W-1:0] d;
  logic [LINK_W-1:0] b;
  logic [LINK_W-1:0] tb;
  logic [CNT_W-1:0]  ts;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] last;
  logic [LINK_W-1:0] p;
  logic [LINK_W-1:0] n;
  logic [LINK_W-1:0] fs;
  logic [LINK_W-1:0] os;
  logic [LINK_W-1:0] bs;
  logic [LINK_W-1:0] szl;
  logic [LINK_W-1:0] nd;
  logic [17:0]       adj;
  logic [SW-1:0]     steps;
  logic [LINK_W-1:0] res;
  logic              ok;
  logic              moved;
  logic [CNT_W-1:0]  copy_len;
  logic [LINK_W-1:0] free_head;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  free_count;
  logic              initialized;
  logic [16:0]       heap_size;
  logic [15:0]       heap_base;
  logic [CNT_W-1:0]  heap_limit;

  store_req_t        mreq;
  logic [LINK_W-1:0] rdata;

  logic [16:0]       lim;
  logic [LINK_W-1:0] rest;
  logic              split;
  logic              fit;
  logic              walk_end;
  logic              valid;
  logic              merge_hit;

  ffha_store #(.AW(AW)) u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    lim = {4'b0, heap_limit};
    if (lim < 17'(MIN_SPLIT))  lim = 17'(MIN_SPLIT);
    if (lim < 17'(NODE_BYTES)) lim = 17'(NODE_BYTES);
    if (lim > 17'(HEAP_MAX))   lim = 17'(HEAP_MAX);
  end

  assign rest      = tb + 16'(NODE_BYTES) + 16'(ts);
  assign split     = {1'b0, fs} >= 17'(ts) + 17'(MIN_SPLIT);
  assign fit       = {1'b0, rdata} >= 17'(ts) + 17'(NODE_BYTES);
  assign walk_end  = (steps == SW'(HEAP_MAX)) || (cur == LINK_NONE);
  assign valid     = (d >= 16'(NODE_BYTES)) && ({1'b0, d} < heap_size);
  assign merge_hit = (18'(last) + 18'(NODE_BYTES) + 18'(rdata)) == {2'b0, cur};

  // store access for the current step
  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = cur;
    mreq.wdata = '0;
    unique case (state)
      ST_INIT_NX: begin mreq.we = 1'b1; mreq.addr = 16'd0; mreq.wdata = LINK_NONE; end
      ST_INIT_PV: begin mreq.we = 1'b1; mreq.addr = 16'd2; mreq.wdata = LINK_NONE; end
      ST_INIT_SZ: begin
        mreq.we = 1'b1; mreq.addr = 16'd4; mreq.wdata = 16'(lim - 17'(NODE_BYTES));
      end
      ST_A_LOOP:  mreq.addr = cur + 16'd4;
      ST_T_SZ, ST_T_TK, ST_G_SZ: mreq.addr = tb + 16'd4;
      ST_T_PV:    mreq.addr = tb + 16'd2;
      ST_T_NX:    mreq.addr = tb;
      ST_T_S1: begin
        mreq.we = 1'b1; mreq.addr = rest + 16'd4;
        mreq.wdata = fs - 16'(ts) - 16'(NODE_BYTES);
      end
      ST_T_S2: begin mreq.we = 1'b1; mreq.addr = tb + 16'd4; mreq.wdata = 16'(ts); end
      ST_T_S3: begin mreq.we = 1'b1; mreq.addr = rest; mreq.wdata = n; end
      ST_T_S4: begin
        mreq.we = (n != LINK_NONE); mreq.addr = n + 16'd2; mreq.wdata = rest;
      end
      ST_T_S5: begin mreq.we = 1'b1; mreq.addr = rest + 16'd2; mreq.wdata = p; end
      ST_T_S6: begin mreq.we = (p != LINK_NONE); mreq.addr = p; mreq.wdata = rest; end
      ST_T_U1: begin mreq.we = (p != LINK_NONE); mreq.addr = p; mreq.wdata = n; end
      ST_T_U2: begin
        mreq.we = (n != LINK_NONE); mreq.addr = n + 16'd2; mreq.wdata = p;
      end
      ST_I_SZ, ST_R_SZ, ST_V_SZ: mreq.addr = b + 16'd4;
      ST_I_LOOP:  mreq.addr = (cur > b) ? cur + 16'd2 : cur;
      ST_I_F1: begin mreq.we = 1'b1; mreq.addr = b; mreq.wdata = cur; end
      ST_I_F2: begin mreq.we = 1'b1; mreq.addr = cur + 16'd2; mreq.wdata = b; end
      ST_I_F3: begin mreq.we = 1'b1; mreq.addr = b + 16'd2; mreq.wdata = p; end
      ST_I_F4: begin mreq.we = (p != LINK_NONE); mreq.addr = p; mreq.wdata = b; end
      ST_I_E1: begin
        mreq.we = 1'b1;
        if (last == LINK_NONE) begin
          mreq.addr = b + 16'd2; mreq.wdata = LINK_NONE;
        end else begin
          mreq.addr = last; mreq.wdata = b;
        end
      end
      ST_I_E2: begin
        mreq.we = (last != LINK_NONE); mreq.addr = b + 16'd2; mreq.wdata = last;
      end
      ST_I_E3: begin mreq.we = 1'b1; mreq.addr = b; mreq.wdata = LINK_NONE; end
      ST_M_N:     mreq.addr = last + 16'd4;
      ST_M_CHK:   mreq.addr = cur + 16'd4;
      ST_M_SUM: begin
        mreq.we = 1'b1; mreq.addr = last + 16'd4;
        mreq.wdata = szl + 16'(NODE_BYTES) + rdata;
      end
      ST_M_NX: begin mreq.we = 1'b1; mreq.addr = last; mreq.wdata = n; end
      ST_M_PV: begin
        mreq.we = (n != LINK_NONE); mreq.addr = n + 16'd2; mreq.wdata = last;
      end
      ST_F_LOOP:  mreq.addr = ({2'b0, cur} == adj) ? cur + 16'd4 : cur;
      ST_G_WR: begin
        mreq.we = 1'b1; mreq.addr = b + 16'd4;
        mreq.wdata = os + rdata + 16'(NODE_BYTES);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      free_head   <= LINK_NONE;
      used_count  <= '0;
      free_count  <= '0;
      initialized <= 1'b0;
      heap_size   <= '0;
      heap_base   <= '0;
      heap_limit  <= 13'd4096;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) heap_base <= cfg_data;
        else                            heap_limit <= cfg_data[CNT_W-1:0];
      end
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            func     <= s_tuser;
            size     <= s_tdata[12:0];
            address  <= s_tdata[28:13];
            d        <= s_tdata[28:13] - heap_base;
            res      <= '0;
            ok       <= 1'b0;
            moved    <= 1'b0;
            copy_len <= '0;
            state    <= initialized ? ST_DISPATCH : ST_INIT_NX;
          end
        end
        ST_INIT_NX: state <= ST_INIT_PV;
        ST_INIT_PV: state <= ST_INIT_SZ;
        ST_INIT_SZ: begin
          heap_size   <= lim;
          free_head   <= '0;
          used_count  <= CNT_W'(NODE_BYTES);
          free_count  <= CNT_W'(lim - 17'(NODE_BYTES));
          initialized <= 1'b1;
          state       <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          priority if (func == FUNC_ALLOC || (func == FUNC_REALLOC && address == '0)) begin
            ts    <= size;
            ret   <= RET_ALLOC;
            cur   <= free_head;
            steps <= '0;
            state <= ST_A_LOOP;
          end else if (func == FUNC_FREE) begin
            if (address == '0) begin
              ok    <= 1'b1;
              state <= ST_DONE;
            end else if (valid) begin
              b     <= d - 16'(NODE_BYTES);
              ok    <= 1'b1;
              state <= ST_I_SZ;
            end else begin
              state <= ST_DONE;
            end
          end else if (func == FUNC_REALLOC && valid) begin
            b     <= d - 16'(NODE_BYTES);
            state <= ST_R_SZ;
          end else begin
            state <= ST_DONE;
          end
        end

        // first-fit walk
        ST_A_LOOP: state <= walk_end ? ST_DONE : ST_A_SZ;
        ST_A_SZ: begin
          if (fit) begin
            tb    <= cur;
            state <= ST_T_SZ;
          end else begin
            state <= ST_A_NX;
          end
        end
        ST_A_NX: begin
          cur   <= rdata;
          steps <= steps + SW'(1);
          state <= ST_A_LOOP;
        end

        // take block tb for ts bytes
        ST_T_SZ: state <= ST_T_PV;
        ST_T_PV: begin fs <= rdata; state <= ST_T_NX; end
        ST_T_NX: begin p <= rdata; state <= ST_T_DEC; end
        ST_T_DEC: begin
          n     <= rdata;
          state <= split ? ST_T_S1 : ST_T_U1;
        end
        ST_T_S1: state <= ST_T_S2;
        ST_T_S2: state <= ST_T_S3;
        ST_T_S3: state <= ST_T_S4;
        ST_T_S4: state <= ST_T_S5;
        ST_T_S5: state <= ST_T_S6;
        ST_T_S6: begin
          if (p == LINK_NONE) free_head <= rest;
          used_count <= used_count + CNT_W'(NODE_BYTES);
          free_count <= free_count - CNT_W'(NODE_BYTES);
          state      <= ST_T_TK;
        end
        ST_T_U1: begin
          if (p == LINK_NONE) free_head <= n;
          state <= ST_T_U2;
        end
        ST_T_U2: state <= ST_T_TK;
        ST_T_TK: state <= ST_T_TK2;
        ST_T_TK2: begin
          used_count <= used_count + rdata[CNT_W-1:0];
          free_count <= free_count - rdata[CNT_W-1:0];
          nd         <= tb + 16'(NODE_BYTES);
          unique case (ret)
            RET_ALLOC: begin
              res   <= heap_base + tb + 16'(NODE_BYTES);
              ok    <= 1'b1;
              state <= ST_DONE;
            end
            RET_MOVE: state <= ST_V_SZ;
            RET_GROW: state <= ST_G_SZ;
            default:  state <= ST_DONE;
          endcase
        end

        // insert b in address order
        ST_I_SZ: state <= ST_I_BS;
        ST_I_BS: begin
          bs    <= rdata;
          last  <= LINK_NONE;
          cur   <= free_head;
          steps <= '0;
          state <= ST_I_LOOP;
        end
        ST_I_LOOP: begin
          priority if (walk_end) state <= ST_I_E1;
          else if (cur > b)      state <= ST_I_F1;
          else begin
            last  <= cur;
            state <= ST_I_NX;
          end
        end
        ST_I_NX: begin
          cur   <= rdata;
          steps <= steps + SW'(1);
          state <= ST_I_LOOP;
        end
        ST_I_F1: begin p <= rdata; state <= ST_I_F2; end
        ST_I_F2: state <= ST_I_F3;
        ST_I_F3: state <= ST_I_F4;
        ST_I_F4: begin
          if (p == LINK_NONE) free_head <= b;
          free_count <= free_count + bs[CNT_W-1:0];
          used_count <= used_count - bs[CNT_W-1:0];
          state      <= ST_M_INIT;
        end
        ST_I_E1: begin
          if (last == LINK_NONE) free_head <= b;
          state <= ST_I_E2;
        end
        ST_I_E2: state <= ST_I_E3;
        ST_I_E3: begin
          free_count <= free_count + bs[CNT_W-1:0];
          used_count <= used_count - bs[CNT_W-1:0];
          state      <= ST_M_INIT;
        end

        // merge pass over the whole list
        ST_M_INIT: begin
          last  <= LINK_NONE;
          cur   <= free_head;
          steps <= '0;
          state <= ST_M_LOOP;
        end
        ST_M_LOOP: state <= walk_end ? ST_DONE : ST_M_N;
        ST_M_N: begin
          n <= rdata;
          if (last == LINK_NONE) begin
            last  <= cur;
            cur   <= rdata;
            steps <= steps + SW'(1);
            state <= ST_M_LOOP;
          end else begin
            state <= ST_M_CHK;
          end
        end
        ST_M_CHK: begin
          szl <= rdata;
          if (merge_hit) begin
            state <= ST_M_SUM;
          end else begin
            last  <= cur;
            cur   <= n;
            steps <= steps + SW'(1);
            state <= ST_M_LOOP;
          end
        end
        ST_M_SUM: state <= ST_M_NX;
        ST_M_NX:  state <= ST_M_PV;
        ST_M_PV: begin
          used_count <= used_count - CNT_W'(NODE_BYTES);
          free_count <= free_count + CNT_W'(NODE_BYTES);
          cur        <= n;
          steps      <= steps + SW'(1);
          state      <= ST_M_LOOP;
        end

        // reallocate
        ST_R_SZ: state <= ST_R_OS;
        ST_R_OS: begin
          os <= rdata;
          if ({3'b0, size} <= rdata) begin
            res   <= address;
            ok    <= 1'b1;
            state <= ST_DONE;
          end else begin
            ts    <= size - rdata[CNT_W-1:0];
            adj   <= 18'(b) + 18'(NODE_BYTES) + 18'(rdata);
            cur   <= free_head;
            steps <= '0;
            state <= ST_F_LOOP;
          end
        end
        ST_F_LOOP: begin
          priority if (walk_end || {2'b0, cur} > adj) begin
            ts    <= size;
            ret   <= RET_MOVE;
            cur   <= free_head;
            steps <= '0;
            state <= ST_A_LOOP;
          end else if ({2'b0, cur} == adj) begin
            state <= ST_F_SZ;
          end else begin
            state <= ST_F_NX;
          end
        end
        ST_F_SZ: begin
          if (rdata >= 16'(ts)) begin
            tb    <= cur;
            ret   <= RET_GROW;
            state <= ST_T_SZ;
          end else begin
            ts    <= size;
            ret   <= RET_MOVE;
            cur   <= free_head;
            steps <= '0;
            state <= ST_A_LOOP;
          end
        end
        ST_F_NX: begin
          cur   <= rdata;
          steps <= steps + SW'(1);
          state <= ST_F_LOOP;
        end
        ST_G_SZ: state <= ST_G_WR;
        ST_G_WR: begin
          res   <= address;
          ok    <= 1'b1;
          state <= ST_DONE;
        end
        ST_V_SZ: state <= ST_V_CP;
        ST_V_CP: begin
          copy_len <= ({3'b0, size} < rdata) ? size : rdata[CNT_W-1:0];
          res      <= heap_base + nd;
          ok       <= 1'b1;
          moved    <= 1'b1;
          state    <= ST_I_SZ;
        end

        ST_DONE: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, free_count, used_count, copy_len, moved, ok, res};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FFHA_ASSERT(a_out_from_done, $rose(m_tvalid) |-> $past(state) == ST_DONE, "result without finished request")
  `FFHA_ASSERT(a_no_write_idle, state == ST_IDLE |-> !mreq.we, "store written while idle")
  `FFHA_ASSERT(a_init_sticky, initialized |=> initialized, "heap layout lost outside reset")
  `FFHA_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid), "reset did not idle the block")

endmodule

// ===== verif/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench for first_fit_heap_allocator. Drives request words,
// predicts each result word with a behavioral heap model or takes it from
// the plan, and compares field by field. Depends on ffha_pkg and the RTL only.
module tb_first_fit_heap_allocator import ffha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned ARENA   = 4096;
  localparam int unsigned HDR     = 6;
  localparam int unsigned SPLIT   = 8;
  localparam int unsigned NO_LINK = 16'hFFFF;

  typedef struct packed {
    logic [15:0] addr;
    logic        ok;
    logic        moved;
    logic [12:0] copy_len;
    logic [12:0] used_n;
    logic [12:0] free_n;
  } reply_t;

  typedef enum int {AM_LIT, AM_NEWEST, AM_OLDEST} addr_mode_t;

  typedef struct {
    logic [1:0]  fn;
    int unsigned sz;
    addr_mode_t  mode;
    logic [15:0] lit;
    bit          chk;
    reply_t      want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  first_fit_heap_allocator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- heap model ----------------
  bit [7:0]    arena [ARENA];
  int unsigned list_head, used_cnt, free_cnt, heap_bytes, base_reg, limit_reg;
  bit          heap_ready;

  function automatic int unsigned rd16(int unsigned o);
    return {arena[(o + 1) % ARENA], arena[o % ARENA]};
  endfunction

  function automatic void wr16(int unsigned o, int unsigned v);
    arena[o % ARENA]       = v[7:0];
    arena[(o + 1) % ARENA] = v[15:8];
  endfunction

  function automatic int unsigned nxt(int unsigned b); return rd16(b); endfunction
  function automatic int unsigned prv(int unsigned b); return rd16(b + 2); endfunction
  function automatic int unsigned bsz(int unsigned b); return rd16(b + 4); endfunction

  function automatic int unsigned take_blk(int unsigned b, int unsigned s);
    int unsigned fs, p, n, rest;
    fs = bsz(b);
    p  = prv(b);
    n  = nxt(b);
    if (fs >= s + SPLIT) begin
      rest = (b + HDR + s) & 16'hFFFF;
      wr16(rest + 4, fs - s - HDR);
      wr16(b + 4, s);
      wr16(rest, n);
      if (n != NO_LINK) wr16(n + 2, rest);
      wr16(rest + 2, p);
      if (p != NO_LINK) wr16(p, rest); else list_head = rest;
      used_cnt += HDR;
      free_cnt -= HDR;
    end else begin
      if (p != NO_LINK) wr16(p, n); else list_head = n;
      if (n != NO_LINK) wr16(n + 2, p);
    end
    used_cnt += bsz(b);
    free_cnt -= bsz(b);
    return b + HDR;
  endfunction

  function automatic int unsigned first_fit(int unsigned s);
    int unsigned cur;
    cur = list_head;
    for (int i = 0; i < ARENA && cur != NO_LINK; i++) begin
      if (bsz(cur) >= s + HDR) return take_blk(cur, s);
      cur = nxt(cur);
    end
    return NO_LINK;
  endfunction

  function automatic void link_in(int unsigned b);
    int unsigned last, cur, p, bs;
    last = NO_LINK;
    cur  = list_head;
    bs   = bsz(b);
    for (int i = 0; i < ARENA && cur != NO_LINK; i++) begin
      if (cur > b) begin
        p = prv(cur);
        wr16(b, cur);
        wr16(cur + 2, b);
        wr16(b + 2, p);
        if (p != NO_LINK) wr16(p, b); else list_head = b;
        free_cnt += bs;
        used_cnt -= bs;
        return;
      end
      last = cur;
      cur  = nxt(cur);
    end
    if (last == NO_LINK) begin
      list_head = b;
      wr16(b + 2, NO_LINK);
    end else begin
      wr16(last, b);
      wr16(b + 2, last);
    end
    wr16(b, NO_LINK);
    free_cnt += bs;
    used_cnt -= bs;
  endfunction

  function automatic void coalesce();
    int unsigned last, cur, n;
    last = NO_LINK;
    cur  = list_head;
    for (int i = 0; i < ARENA && cur != NO_LINK; i++) begin
      n = nxt(cur);
      if (last != NO_LINK && last + HDR + bsz(last) == cur) begin
        wr16(last + 4, bsz(last) + HDR + bsz(cur));
        wr16(last, n);
        if (n != NO_LINK) wr16(n + 2, last);
        used_cnt -= HDR;
        free_cnt += HDR;
      end else begin
        last = cur;
      end
      cur = n;
    end
  endfunction

  function automatic int unsigned next_free_fit(int unsigned b, int unsigned g);
    int unsigned adj, cur;
    adj = b + HDR + bsz(b);
    cur = list_head;
    for (int i = 0; i < ARENA && cur != NO_LINK; i++) begin
      if (cur == adj) return (bsz(cur) >= g) ? cur : NO_LINK;
      if (cur > adj) return NO_LINK;
      cur = nxt(cur);
    end
    return NO_LINK;
  endfunction

  function automatic bit in_heap(int unsigned a);
    int unsigned d;
    d = (a - base_reg) & 16'hFFFF;
    return d >= HDR && d < heap_bytes;
  endfunction

  function automatic reply_t heap_request(logic [1:0] fn, int unsigned s, int unsigned a);
    reply_t      r;
    int unsigned d, b, os, nd, nbr, nb, res, ok, mv, cp;
    bit          valid;
    res = 0; ok = 0; mv = 0; cp = 0;
    if (!heap_ready) begin
      heap_bytes = limit_reg;
      if (heap_bytes < SPLIT) heap_bytes = SPLIT;
      if (heap_bytes > ARENA) heap_bytes = ARENA;
      wr16(0, NO_LINK);
      wr16(2, NO_LINK);
      wr16(4, heap_bytes - HDR);
      list_head  = 0;
      used_cnt   = HDR;
      free_cnt   = heap_bytes - HDR;
      heap_ready = 1'b1;
    end
    d = (a - base_reg) & 16'hFFFF;
    valid = in_heap(a);
    if (fn == FUNC_ALLOC || (fn == FUNC_REALLOC && a == 0)) begin
      nd = first_fit(s);
      if (nd != NO_LINK) begin res = base_reg + nd; ok = 1; end
    end else if (fn == FUNC_FREE) begin
      if (a == 0) ok = 1;
      else if (valid) begin
        link_in(d - HDR);
        coalesce();
        ok = 1;
      end
    end else if (fn == FUNC_REALLOC && valid) begin
      b  = d - HDR;
      os = bsz(b);
      if (s <= os) begin
        res = a; ok = 1;
      end else begin
        nbr = next_free_fit(b, s - os);
        if (nbr != NO_LINK) begin
          nb = take_blk(nbr, s - os) - HDR;
          wr16(b + 4, os + bsz(nb) + HDR);
          res = a; ok = 1;
        end else begin
          nd = first_fit(s);
          if (nd != NO_LINK) begin
            cp = (s < bsz(b)) ? s : bsz(b);
            link_in(b);
            coalesce();
            res = base_reg + nd; ok = 1; mv = 1;
          end
        end
      end
    end
    r.addr     = res[15:0];
    r.ok       = ok[0];
    r.moved    = mv[0];
    r.copy_len = cp[12:0];
    r.used_n   = used_cnt[12:0];
    r.free_n   = free_cnt[12:0];
    return r;
  endfunction

  // ---------------- bookkeeping ----------------
  reply_t      pending_q[$];
  int unsigned live_off[$];
  int          errors = 0;
  int          words_in = 0, words_out = 0, moves_seen = 0, fails_seen = 0;
  int          hold_req = 0;
  bit          done = 1'b0;

  task automatic report(string what, int unsigned got, int unsigned want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    reply_t g, w;
    if (!rst && m_tvalid && m_tready) begin
      g.addr     = m_tdata[15:0];
      g.ok       = m_tdata[16];
      g.moved    = m_tdata[17];
      g.copy_len = m_tdata[30:18];
      g.used_n   = m_tdata[43:31];
      g.free_n   = m_tdata[56:44];
      if (pending_q.size() == 0) begin
        report("result word count", words_out + 1, words_in);
      end else begin
        w = pending_q.pop_front();
        words_out++;
        if (g.addr != w.addr) report("result_address", g.addr, w.addr);
        if (g.ok != w.ok) report("ok", g.ok, w.ok);
        if (g.moved != w.moved) report("moved", g.moved, w.moved);
        if (g.copy_len != w.copy_len) report("copy_length", g.copy_len, w.copy_len);
        if (g.used_n != w.used_n) report("used_bytes", g.used_n, w.used_n);
        if (g.free_n != w.free_n) report("free_bytes", g.free_n, w.free_n);
        if (w.moved) moves_seen++;
        if (!w.ok) fails_seen++;
      end
    end
  end

  // receiver: windowed stall pattern plus an occasional long hold-off
  always @(negedge clk) begin
    int unsigned win, mode, hold_left, hold_seen;
    if (win == 0) begin
      win  = $urandom_range(16, 96);
      mode = $urandom_range(0, 2);
    end
    win--;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) base_reg = val;
    else limit_reg = val & 16'h1FFF;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one request word; live_idx names the tracked block it refers to, or -1
  task automatic send_req(logic [1:0] fn, int unsigned s, logic [15:0] a, int live_idx,
                          bit use_want, reply_t want);
    reply_t r;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {3'b000, a, s[12:0]};
    do @(posedge clk); while (!s_tready);
    words_in++;
    r = heap_request(fn, s, a);
    pending_q.push_back(use_want ? want : r);
    if (fn == FUNC_ALLOC || (fn == FUNC_REALLOC && a == 0)) begin
      if (r.ok) live_off.push_back((r.addr - base_reg) & 16'hFFFF);
    end else if (live_idx >= 0 && a != 0) begin
      if (fn == FUNC_FREE) live_off.delete(live_idx);
      else if (fn == FUNC_REALLOC && r.moved)
        live_off[live_idx] = (r.addr - base_reg) & 16'hFFFF;
    end
  endtask

  task automatic pause_sender();
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat ($urandom_range(0, 12)) @(negedge clk);
  endtask

  function automatic int unsigned rand_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 40);
    if (p < 95) return $urandom_range(0, 400);
    return $urandom_range(0, 4096);
  endfunction

  function automatic logic [15:0] outside_addr();
    logic [15:0] a;
    a = 16'($urandom);
    if (in_heap(a)) a = 16'(base_reg + $urandom_range(0, HDR - 1));
    return a;
  endfunction

  task automatic random_phase(int n, bit squeeze);
    int          burst, idx;
    int unsigned p, s;
    logic [1:0]  fn;
    logic [15:0] a;
    reply_t      none;
    none  = '0;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 40);
      end
      burst--;
      if (squeeze && k == 30) hold_req++;
      p   = $urandom_range(0, 99);
      s   = rand_size();
      idx = -1;
      a   = '0;
      if (live_off.size() > 50 && p < 40) p = 50;
      if (p < 40 || live_off.size() == 0 && p < 85) begin
        fn = FUNC_ALLOC;
      end else if (p < 70) begin
        fn  = FUNC_FREE;
        idx = $urandom_range(0, live_off.size() - 1);
        a   = 16'(base_reg + live_off[idx]);
      end else if (p < 85) begin
        fn  = FUNC_REALLOC;
        idx = $urandom_range(0, live_off.size() - 1);
        a   = 16'(base_reg + live_off[idx]);
      end else if (p < 89) begin
        fn = FUNC_REALLOC;
      end else if (p < 93) begin
        fn = FUNC_UNUSED;
        a  = 16'($urandom);
      end else if (p < 95) begin
        fn = FUNC_FREE;
      end else begin
        fn = ($urandom_range(0, 1) == 0) ? FUNC_FREE : FUNC_REALLOC;
        a  = outside_addr();
      end
      send_req(fn, s, a, idx, 1'b0, none);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  row_t plan[20];

  initial begin
    int          idx;
    logic [15:0] a;
    heap_ready = 1'b0;
    list_head  = NO_LINK;
    used_cnt   = 0;
    free_cnt   = 0;
    heap_bytes = 0;
    base_reg   = 0;
    limit_reg  = 4096;

    plan[0]  = '{FUNC_ALLOC,   0,    AM_LIT,    16'h0000, 1, '{16'd6, 1, 0, 0, 12, 4084}};
    plan[1]  = '{FUNC_UNUSED,  77,   AM_LIT,    16'h0040, 1, '{0, 0, 0, 0, 12, 4084}};
    plan[2]  = '{FUNC_FREE,    0,    AM_LIT,    16'h0000, 1, '{0, 1, 0, 0, 12, 4084}};
    plan[3]  = '{FUNC_FREE,    0,    AM_LIT,    16'h0003, 1, '{0, 0, 0, 0, 12, 4084}};
    plan[4]  = '{FUNC_FREE,    0,    AM_LIT,    16'hFFFF, 1, '{0, 0, 0, 0, 12, 4084}};
    plan[5]  = '{FUNC_ALLOC,   4096, AM_LIT,    16'h0000, 1, '{0, 0, 0, 0, 12, 4084}};
    plan[6]  = '{FUNC_REALLOC, 10,   AM_LIT,    16'h0000, 1, '{16'd12, 1, 0, 0, 28, 4068}};
    plan[7]  = '{FUNC_REALLOC, 5,    AM_LIT,    16'hFFFF, 1, '{0, 0, 0, 0, 28, 4068}};
    plan[8]  = '{FUNC_ALLOC,   100,  AM_LIT,    16'h0000, 0, '0};
    plan[9]  = '{FUNC_REALLOC, 50,   AM_NEWEST, 16'h0000, 0, '0};
    plan[10] = '{FUNC_REALLOC, 300,  AM_NEWEST, 16'h0000, 0, '0};
    plan[11] = '{FUNC_REALLOC, 40,   AM_OLDEST, 16'h0000, 0, '0};
    plan[12] = '{FUNC_ALLOC,   4096, AM_LIT,    16'h0000, 0, '0};
    plan[13] = '{FUNC_FREE,    0,    AM_NEWEST, 16'h0000, 0, '0};
    plan[14] = '{FUNC_FREE,    0,    AM_OLDEST, 16'h0000, 0, '0};
    plan[15] = '{FUNC_ALLOC,   3000, AM_LIT,    16'h0000, 0, '0};
    plan[16] = '{FUNC_REALLOC, 4000, AM_NEWEST, 16'h0000, 0, '0};
    plan[17] = '{FUNC_FREE,    0,    AM_NEWEST, 16'h0000, 0, '0};
    plan[18] = '{FUNC_FREE,    0,    AM_OLDEST, 16'h0000, 0, '0};
    plan[19] = '{FUNC_ALLOC,   8191 & 4095, AM_LIT, 16'h0000, 0, '0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write(REG_HEAP_BASE, 16'h0000);
    cfg_write(REG_HEAP_LIMIT, 16'd4096);

    foreach (plan[i]) begin
      idx = -1;
      a   = plan[i].lit;
      if (plan[i].mode != AM_LIT && live_off.size() != 0) begin
        idx = (plan[i].mode == AM_NEWEST) ? live_off.size() - 1 : 0;
        a   = 16'(base_reg + live_off[idx]);
      end
      send_req(plan[i].fn, plan[i].sz, a, idx, plan[i].chk, plan[i].want);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();

    // heap size is latched already; later limit writes must not change it
    random_phase(300, 1'b1);
    wait_drained();
    cfg_write(REG_HEAP_BASE, 16'hFFFF);
    cfg_write(REG_HEAP_LIMIT, 16'd8);
    random_phase(300, 1'b0);
    wait_drained();
    cfg_write(REG_HEAP_BASE, 16'($urandom));
    cfg_write(REG_HEAP_LIMIT, 16'h1FFF);
    random_phase(310, 1'b1);
    wait_drained();
    cfg_write(REG_HEAP_BASE, 16'h8000);
    cfg_write(REG_HEAP_LIMIT, 16'd0);
    random_phase(310, 1'b0);
    wait_drained();
    cfg_write(REG_HEAP_BASE, 16'h0000);
    cfg_write(REG_HEAP_LIMIT, 16'd4096);
    random_phase(310, 1'b0);

    wait_drained();
    repeat (200) @(posedge clk);
    done = 1'b1;
    $display("covered %0d requests, %0d results checked, %0d moves, %0d refusals",
             words_in, words_out, moves_seen, fails_seen);
    $display("heap base swept over 0, 0xFFFF, random and 0x8000; limit writes 0 to 8191");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    if (!done) begin
      $display("timeout with %0d results outstanding", pending_q.size());
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_store.sv
hdl/first_fit_heap_allocator.sv
verif/tb_first_fit_heap_allocator.sv
